@@ hdl/jet_pkg.sv @@
`default_nettype none

package jet_pkg;

  // fixed field widths
  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 28;
  localparam int COUNT_BITS = 16;
  localparam int SCALE_BITS = 31;
  localparam int Z_BITS     = 32;
  localparam int COLOR_BITS = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // scaled coordinate product and the widened subtract result
  localparam int PROD_W = COORD_BITS + SCALE_BITS;
  localparam int WIDE_W = 66;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_RE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_IM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_C_RE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_C_IM      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_COLOR  = 3'd6;

  // register reset values
  localparam logic [SCALE_BITS-1:0] RST_SCALE     = 31'd1342177;
  localparam logic [Z_BITS-1:0]     RST_OFFSET_RE = 32'd536870912;
  localparam logic [Z_BITS-1:0]     RST_OFFSET_IM = 32'd536870912;
  localparam logic [Z_BITS-1:0]     RST_C_RE      = 32'hF3333333;
  localparam logic [Z_BITS-1:0]     RST_C_IM      = 32'd72470613;
  localparam logic [COUNT_BITS-1:0] RST_MAX_ITER  = 16'd100;
  localparam logic [COLOR_BITS-1:0] RST_IN_COLOR  = 32'd0;

  // escape bound |z|^2 > 4, in Q8.56
  localparam logic [63:0] ESC_LIMIT = 64'd4 << (2 * FRAC_BITS);

  // saturation bounds in the wide signed format
  localparam logic signed [WIDE_W-1:0] SAT_HI = {{(WIDE_W-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [WIDE_W-1:0] SAT_LO = {{(WIDE_W-31){1'b1}}, {31{1'b0}}};

  typedef struct packed {
    logic [COORD_BITS-1:0] pix_x;
    logic [COORD_BITS-1:0] pix_y;
  } jet_in_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] out_x;
    logic [COORD_BITS-1:0] out_y;
    logic [COUNT_BITS-1:0] iter_count;
    logic                  inside_res;
    logic [COLOR_BITS-1:0] pixel_color;
  } jet_out_t;

  // start point handed from front to back
  typedef struct packed {
    logic [COORD_BITS-1:0]    x;
    logic [COORD_BITS-1:0]    y;
    logic signed [Z_BITS-1:0] zr;
    logic signed [Z_BITS-1:0] zi;
  } jet_start_t;

  typedef struct packed {
    logic [SCALE_BITS-1:0]    scale;
    logic signed [Z_BITS-1:0] offset_re;
    logic signed [Z_BITS-1:0] offset_im;
    logic signed [Z_BITS-1:0] c_re;
    logic signed [Z_BITS-1:0] c_im;
    logic [COUNT_BITS-1:0]    max_iter;
    logic [COLOR_BITS-1:0]    inside_color;
  } jet_cfg_t;

  // clamp a wide signed value to the signed 32-bit range
  function automatic logic signed [Z_BITS-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [Z_BITS-1:0] r;
    if (v > SAT_HI) begin
      r = {1'b0, {(Z_BITS-1){1'b1}}};
    end else if (v < SAT_LO) begin
      r = {1'b1, {(Z_BITS-1){1'b0}}};
    end else begin
      r = v[Z_BITS-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/jet_front.sv @@
`default_nettype none

module jet_front
  import jet_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire jet_cfg_t   cfg,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire jet_in_t    in_data,
  output logic            q_valid,
  input  wire logic       q_ready,
  output jet_start_t      q_data
);

  logic                  s1_valid_r, s1_valid_nxt;
  logic [COORD_BITS-1:0] x_r, y_r;
  logic [PROD_W-1:0]     px_prod_r, py_prod_r;
  logic                  take;
  logic signed [WIDE_W-1:0] zr_wide, zi_wide;

  // stage holds one scaled pixel until the queue takes it
  assign in_ready = !s1_valid_r || q_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (take) begin
      s1_valid_nxt = 1'b1;
    end else if (q_ready) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // pixel times scale, registered
  always_ff @(posedge clk) begin
    if (take) begin
      x_r       <= in_data.pix_x;
      y_r       <= in_data.pix_y;
      px_prod_r <= PROD_W'(in_data.pix_x) * PROD_W'(cfg.scale);
      py_prod_r <= PROD_W'(in_data.pix_y) * PROD_W'(cfg.scale);
    end
  end

  // subtract the offset and clamp to the start point
  assign zr_wide = $signed({{(WIDE_W-PROD_W){1'b0}}, px_prod_r})
                 - $signed({{(WIDE_W-Z_BITS){cfg.offset_re[Z_BITS-1]}}, cfg.offset_re});
  assign zi_wide = $signed({{(WIDE_W-PROD_W){1'b0}}, py_prod_r})
                 - $signed({{(WIDE_W-Z_BITS){cfg.offset_im[Z_BITS-1]}}, cfg.offset_im});

  assign q_valid   = s1_valid_r;
  assign q_data.x  = x_r;
  assign q_data.y  = y_r;
  assign q_data.zr = sat32(zr_wide);
  assign q_data.zi = sat32(zi_wide);

endmodule

`default_nettype wire

@@ hdl/jet_queue.sv @@
`default_nettype none

module jet_queue
  import jet_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       wr_valid,
  output logic            wr_ready,
  input  wire jet_start_t wr_data,
  output logic            rd_valid,
  input  wire logic       rd_ready,
  output jet_start_t      rd_data
);

  // depth must be a power of two so the pointers wrap on their own; the queue does not check it
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  jet_start_t       mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             push, pop;

  assign wr_ready = (cnt_r != CNT_W'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem[rd_ptr_r];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

@@ hdl/jet_core.sv @@
`default_nettype none

module jet_core
  import jet_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire jet_cfg_t   cfg,
  input  wire logic       q_valid,
  output logic            q_ready,
  input  wire jet_start_t q_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output jet_out_t        out_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]               state_r, state_nxt;
  logic                     first_r, first_nxt;
  logic [COUNT_BITS-1:0]    cnt_r, cnt_nxt;
  logic signed [Z_BITS-1:0] zr_r, zr_nxt;
  logic signed [Z_BITS-1:0] zi_r, zi_nxt;
  logic [COORD_BITS-1:0]    x_r, y_r;
  logic signed [63:0]       sqr_r, sqi_r, crs_r;
  logic                     out_valid_r, out_valid_nxt;
  jet_out_t                 out_data_r;

  logic                     load_out;
  logic [63:0]              mag;
  logic                     esc;
  logic signed [63:0]       diff, diff_sh, crs_sh;
  logic signed [WIDE_W-1:0] nx_wide, ny_wide;
  logic [COUNT_BITS-1:0]    cnt_inc;
  logic                     in_res;

  assign q_ready  = (state_r == ST_IDLE);
  assign load_out = (state_r == ST_FIN) && (!out_valid_r || out_ready);

  // escape test on the squares of the current point
  assign mag = $unsigned(sqr_r) + $unsigned(sqi_r);
  assign esc = !first_r && (mag > ESC_LIMIT);

  // next point: z^2 + c, floored and clamped
  assign diff    = sqr_r - sqi_r;
  assign diff_sh = diff >>> FRAC_BITS;
  assign crs_sh  = crs_r >>> (FRAC_BITS - 1);
  assign nx_wide = $signed({{(WIDE_W-64){diff_sh[63]}}, diff_sh})
                 + $signed({{(WIDE_W-Z_BITS){cfg.c_re[Z_BITS-1]}}, cfg.c_re});
  assign ny_wide = $signed({{(WIDE_W-64){crs_sh[63]}}, crs_sh})
                 + $signed({{(WIDE_W-Z_BITS){cfg.c_im[Z_BITS-1]}}, cfg.c_im});

  assign cnt_inc = first_r ? cnt_r : cnt_r + COUNT_BITS'(1);

  // iteration sequencer
  always_comb begin
    state_nxt = state_r;
    first_nxt = first_r;
    cnt_nxt   = cnt_r;
    zr_nxt    = zr_r;
    zi_nxt    = zi_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          state_nxt = ST_MUL;
          first_nxt = 1'b1;
          cnt_nxt   = COUNT_BITS'(1);
          zr_nxt    = q_data.zr;
          zi_nxt    = q_data.zi;
        end
      end
      ST_MUL: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (esc) begin
          state_nxt = ST_FIN;
        end else if (cnt_inc < cfg.max_iter) begin
          state_nxt = ST_MUL;
          first_nxt = 1'b0;
          cnt_nxt   = cnt_inc;
          zr_nxt    = sat32(nx_wide);
          zi_nxt    = sat32(ny_wide);
        end else begin
          state_nxt = ST_FIN;
          cnt_nxt   = cnt_inc;
        end
      end
      ST_FIN: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // working point, count and pixel tag
  always_ff @(posedge clk) begin
    first_r <= first_nxt;
    cnt_r   <= cnt_nxt;
    zr_r    <= zr_nxt;
    zi_r    <= zi_nxt;
    if (q_valid && q_ready) begin
      x_r <= q_data.x;
      y_r <= q_data.y;
    end
  end

  // squares and cross product, registered
  always_ff @(posedge clk) begin
    if (state_r == ST_MUL) begin
      sqr_r <= zr_r * zr_r;
      sqi_r <= zi_r * zi_r;
      crs_r <= zr_r * zi_r;
    end
  end

  // result register
  assign in_res = (cnt_r == cfg.max_iter);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r.out_x       <= x_r;
      out_data_r.out_y       <= y_r;
      out_data_r.iter_count  <= cnt_r;
      out_data_r.inside_res  <= in_res;
      out_data_r.pixel_color <= in_res ? cfg.inside_color : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ hdl/julia_escape_time.sv @@
// Julia set escape-time pixel engine, Q4.28 fixed point.
// Input channel (in_valid/in_ready/in_data) takes one pixel coordinate per
// transfer; output channel (out_valid/out_ready/out_data) returns one result
// per pixel, in input order: the coordinate, the iteration count, the inside
// flag and the pixel color (the inside color when inside, else zero).
// Configuration is a plain write port (cfg_we, cfg_index, cfg_wdata); write
// only while no pixel is in flight. Unknown indexes are ignored.
// The front scales the pixel in one registered stage and pushes the start
// point into a QUEUE_DEPTH entry queue once it has room. The back iterates
// one pixel at a time; each iteration registers the products, then runs the
// update and escape test. A limit of zero costs the back as much time as a
// limit of one, and the default limit is 100.
// Reset restores the register defaults and empties the front, queue and
// result register. When the receiver stalls, the finished result waits in
// the output register while the queue keeps taking new pixels until full;
// the back holds its next result until the output register frees up.
`default_nettype none

module julia_escape_time
  import jet_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire jet_in_t               in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output jet_out_t                   out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  jet_cfg_t   cfg_r, cfg_nxt;
  logic       fq_valid, fq_ready;
  jet_start_t fq_data;
  logic       qc_valid, qc_ready;
  jet_start_t qc_data;

  // register file
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_SCALE:     cfg_nxt.scale        = cfg_wdata[SCALE_BITS-1:0];
        CFG_OFFSET_RE: cfg_nxt.offset_re    = cfg_wdata;
        CFG_OFFSET_IM: cfg_nxt.offset_im    = cfg_wdata;
        CFG_C_RE:      cfg_nxt.c_re         = cfg_wdata;
        CFG_C_IM:      cfg_nxt.c_im         = cfg_wdata;
        CFG_MAX_ITER:  cfg_nxt.max_iter     = cfg_wdata[COUNT_BITS-1:0];
        CFG_IN_COLOR:  cfg_nxt.inside_color = cfg_wdata;
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.scale        <= RST_SCALE;
      cfg_r.offset_re    <= RST_OFFSET_RE;
      cfg_r.offset_im    <= RST_OFFSET_IM;
      cfg_r.c_re         <= RST_C_RE;
      cfg_r.c_im         <= RST_C_IM;
      cfg_r.max_iter     <= RST_MAX_ITER;
      cfg_r.inside_color <= RST_IN_COLOR;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // pixel scaling
  jet_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (fq_valid),
    .q_ready  (fq_ready),
    .q_data   (fq_data)
  );

  // start point queue
  jet_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_data  (fq_data),
    .rd_valid (qc_valid),
    .rd_ready (qc_ready),
    .rd_data  (qc_data)
  );

  // iteration engine and result register
  jet_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (qc_valid),
    .q_ready   (qc_ready),
    .q_data    (qc_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ hdl/jet_checker.sv @@
`default_nettype none

module jet_checker
  import jet_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     out_valid,
  input wire logic     out_ready,
  input wire jet_out_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // the count starts at one
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.iter_count != '0)
    else $error("zero iteration count");

  // escaped pixels carry no color
  a_escaped_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.inside_res |-> out_data.pixel_color == '0)
    else $error("escaped pixel with color");

  // reset empties the result register
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind julia_escape_time jet_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
